// ===== rtl/core/spc_pkg.sv =====
// ----------------------------------------------------------------------------
// spc_pkg: shared types and codes of the stepper position controller
// Event kinds, axis status codes, direction codes and position width.
// ----------------------------------------------------------------------------
package spc_pkg;

   // Position counters are POS_W bits wide (8 .. 32); ports stay 32 bits.
   localparam int POS_W = 32;

   typedef logic [POS_W-1:0] pos_type;
   typedef logic [2:0]       kind_type;
   typedef logic [2:0]       status_type;
   typedef logic [1:0]       dir_type;

   // Event kinds
   localparam kind_type KIND_MOVE  = 3'd0;
   localparam kind_type KIND_CAL   = 3'd1;
   localparam kind_type KIND_STEP  = 3'd2;
   localparam kind_type KIND_LIMIT = 3'd3;
   localparam kind_type KIND_ESTOP = 3'd4;

   // Axis status
   localparam status_type ST_FREE    = 3'd0;
   localparam status_type ST_FWD     = 3'd1;
   localparam status_type ST_BACK    = 3'd2;
   localparam status_type ST_CAL_MIN = 3'd3;
   localparam status_type ST_CAL_MAX = 3'd4;
   localparam status_type ST_ESTOP   = 3'd5;

   // Travel direction
   localparam dir_type DIR_NONE = 2'd0;
   localparam dir_type DIR_FWD  = 2'd1;
   localparam dir_type DIR_BACK = 2'd2;

   localparam pos_type POS_ONES = '1;
   localparam pos_type POS_ZERO = '0;
   localparam pos_type POS_ONE  = pos_type'(1);

endpackage

// ===== rtl/core/step_position_controller.sv =====
// ----------------------------------------------------------------------------
// step_position_controller: stepper axis position controller with homing
// Tracks status, position, learned maximum, target and direction of one axis.
// ----------------------------------------------------------------------------
// One transaction per cycle as long as rsp_stall stays low: each request
// (move, calibrate, step done, limit switch, emergency stop) is captured in
// an input register, evaluated against the axis state, and its response is
// registered into the axis state and shown on the rsp_ port. The axis state
// registers double as the response register: they change only when a new
// response replaces the one on the port. A move is taken only when the axis
// is free and stays within 0..max; a zero-length move is always accepted and
// does nothing. Emergency stop latches until reset.
module step_position_controller (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  spc_pkg::kind_type     req_kind,
   input  logic [1:0]            req_move_direction,
   input  logic [31:0]           req_pulse_count,
   input  logic                  req_limit_is_max,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_accepted,
   output spc_pkg::status_type   rsp_axis_status,
   output logic [31:0]           rsp_position,
   output logic                  rsp_motor_running,
   output logic                  rsp_drive_backward,
   output logic [31:0]           rsp_max_position
);
   import spc_pkg::*;

   // input register
   logic        in_valid_ff, in_valid_in;
   kind_type    kind_ff;
   dir_type     mdir_ff;
   logic [31:0] pulses_ff;
   logic        is_max_ff;

   // axis state, also the response payload
   status_type  status_ff, status_in;
   pos_type     position_ff, position_in;
   pos_type     max_ff, max_in;
   pos_type     target_ff, target_in;
   dir_type     dir_ff, dir_in;
   logic        running_ff, running_in;
   logic        dir_pin_ff, dir_pin_in;
   logic        accepted_ff, accepted_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic        advance;
   logic        req_take;
   logic [31:0] pos_wide;
   logic [31:0] max_wide;
   logic        fwd_fits;
   logic        back_fits;
   pos_type     pos_inc;
   pos_type     pos_dec;

   function automatic logic req_pulse_count_le_max(input logic [31:0] p,
                                                    input logic [31:0] m);
      return p <= m;
   endfunction

   // Advance the evaluated transaction when the response slot is empty or
   // being drained this cycle.
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   // Range checks for a move, done at the 32-bit width of pulse_count.
   assign pos_wide  = 32'(position_ff);
   assign max_wide  = 32'(max_ff);
   assign fwd_fits  = (req_pulse_count_le_max(pulses_ff, max_wide)) &&
                      (pos_wide <= max_wide - pulses_ff);
   assign back_fits = pulses_ff <= pos_wide;

   assign pos_inc = position_ff + POS_ONE;
   assign pos_dec = position_ff - POS_ONE;

   // Next axis state for the transaction held in the input register.
   always_comb begin
      status_in   = status_ff;
      position_in = position_ff;
      max_in      = max_ff;
      target_in   = target_ff;
      dir_in      = dir_ff;
      running_in  = running_ff;
      dir_pin_in  = dir_pin_ff;
      accepted_in = 1'b0;

      case (kind_ff)
         KIND_MOVE: begin
            if (pulses_ff == 32'd0) begin
               // zero-length move: accept, change nothing
               accepted_in = 1'b1;
            end else if (status_ff == ST_FREE) begin
               if (mdir_ff == DIR_FWD && fwd_fits) begin
                  target_in   = pos_type'(pos_wide + pulses_ff);
                  dir_pin_in  = 1'b0;
                  status_in   = ST_FWD;
                  dir_in      = DIR_FWD;
                  running_in  = 1'b1;
                  accepted_in = 1'b1;
               end else if (mdir_ff == DIR_BACK && back_fits) begin
                  target_in   = pos_type'(pos_wide - pulses_ff);
                  dir_pin_in  = 1'b1;
                  status_in   = ST_BACK;
                  dir_in      = DIR_BACK;
                  running_in  = 1'b1;
                  accepted_in = 1'b1;
               end
            end
         end
         KIND_CAL: begin
            if (status_ff == ST_FREE) begin
               // home toward the minimum switch from an unknown position
               position_in = POS_ONES;
               target_in   = POS_ZERO;
               max_in      = POS_ONES;
               dir_in      = DIR_BACK;
               dir_pin_in  = 1'b1;
               status_in   = ST_CAL_MIN;
               running_in  = 1'b1;
               accepted_in = 1'b1;
            end
         end
         KIND_STEP: begin
            if (running_ff) begin
               if (dir_ff == DIR_FWD) begin
                  if (position_ff >= max_ff) begin
                     running_in = 1'b0;
                     status_in  = ST_ESTOP;
                  end else begin
                     position_in = pos_inc;
                     if (pos_inc == target_ff) begin
                        running_in = 1'b0;
                        status_in  = ST_FREE;
                     end else if (pos_inc > target_ff) begin
                        running_in = 1'b0;
                        status_in  = ST_ESTOP;
                     end
                  end
               end else if (dir_ff == DIR_BACK) begin
                  if (position_ff == POS_ZERO) begin
                     running_in = 1'b0;
                     status_in  = ST_ESTOP;
                  end else begin
                     position_in = pos_dec;
                     if (pos_dec == target_ff) begin
                        running_in = 1'b0;
                        status_in  = ST_FREE;
                     end else if (pos_dec < target_ff) begin
                        running_in = 1'b0;
                        status_in  = ST_ESTOP;
                     end
                  end
               end else begin
                  // running with no direction set
                  running_in = 1'b0;
                  status_in  = ST_ESTOP;
               end
            end
         end
         KIND_LIMIT: begin
            running_in = 1'b0;
            if (status_ff == ST_CAL_MIN && !is_max_ff) begin
               // home found: start the run toward the maximum switch
               status_in   = ST_CAL_MAX;
               position_in = POS_ZERO;
               max_in      = POS_ONES;
               dir_in      = DIR_FWD;
               target_in   = POS_ONES;
               dir_pin_in  = 1'b0;
               running_in  = 1'b1;
            end else if (status_ff == ST_CAL_MAX) begin
               if (is_max_ff) begin
                  // learn travel range
                  target_in = POS_ZERO;
                  dir_in    = DIR_NONE;
                  max_in    = position_ff;
                  status_in = ST_FREE;
               end
            end else begin
               status_in = ST_ESTOP;
            end
         end
         KIND_ESTOP: begin
            running_in = 1'b0;
            status_in  = ST_ESTOP;
         end
         default: begin
            // unused kinds: no effect
         end
      endcase
   end

   // Capture the request payload.
   always_ff @(posedge clock) begin
      if (req_take) begin
         kind_ff   <= req_kind;
         mdir_ff   <= req_move_direction;
         pulses_ff <= req_pulse_count;
         is_max_ff <= req_limit_is_max;
      end
   end

   // Handshake state and axis state.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         status_ff    <= ST_FREE;
         position_ff  <= POS_ZERO;
         max_ff       <= POS_ZERO;
         target_ff    <= POS_ZERO;
         dir_ff       <= DIR_NONE;
         running_ff   <= 1'b0;
         dir_pin_ff   <= 1'b0;
         accepted_ff  <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            status_ff   <= status_in;
            position_ff <= position_in;
            max_ff      <= max_in;
            target_ff   <= target_in;
            dir_ff      <= dir_in;
            running_ff  <= running_in;
            dir_pin_ff  <= dir_pin_in;
            accepted_ff <= accepted_in;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_accepted       = accepted_ff;
   assign rsp_axis_status    = status_ff;
   assign rsp_position       = 32'(position_ff);
   assign rsp_motor_running  = running_ff;
   assign rsp_drive_backward = dir_pin_ff;
   assign rsp_max_position   = 32'(max_ff);

   // Emergency stop latches until reset.
   a_estop_latched: assert property (@(posedge clock) disable iff (reset)
      status_ff == ST_ESTOP |=> status_ff == ST_ESTOP)
      else $error("emergency stop released without reset");

   // The motor only runs while the axis is moving or calibrating.
   a_run_status: assert property (@(posedge clock) disable iff (reset)
      running_ff |-> (status_ff != ST_FREE && status_ff != ST_ESTOP))
      else $error("motor running while axis free or stopped");

   // A free axis is always inside its travel range.
   a_free_in_range: assert property (@(posedge clock) disable iff (reset)
      status_ff == ST_FREE |-> position_ff <= max_ff)
      else $error("free axis outside 0..max");

   // The axis state never moves while a response waits on a stalled port.
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> $stable(position_ff) && $stable(status_ff))
      else $error("axis state changed under a stalled response");

endmodule

// ===== test/tb_step_position_controller.sv =====
// ----------------------------------------------------------------------------
// tb_step_position_controller: testbench of the stepper position controller
// Feeds move, calibrate, step, limit and stop events over the valid/stall
// request channel, predicts the axis state of every transaction and compares
// each response field by field, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_step_position_controller;
   import spc_pkg::*;

   // Kinds that the block must ignore, and a direction code it must reject
   localparam kind_type KIND_SPARE5 = 3'd5;
   localparam kind_type KIND_SPARE7 = 3'd7;
   localparam dir_type  DIR_BAD     = 2'd3;

   localparam int RANDOM_EVENTS = 820;  // events in the random part
   localparam int IDLE_PERCENT  = 12;   // idling rate of each channel
   localparam int CAL_SPAN_CAP  = 150;  // longest learned travel in random runs
   localparam int SETTLE_CYCLES = 8;    // margin to catch stray responses
   localparam int STALL_LIMIT   = 2000; // cycles without any transaction
   localparam int MAX_REPORTS   = 10;

   // Predicted axis state; all-zero is the state after reset
   typedef struct packed {
      status_type status;
      pos_type    pos;
      pos_type    top;       // learned maximum
      pos_type    target;
      dir_type    dir;
      logic       running;
      logic       pin_back;  // direction pin
   } axis_state_type;

   typedef struct packed {
      logic       accepted;
      status_type status;
      pos_type    position;
      logic       running;
      logic       backward;
      pos_type    max_pos;
   } axis_report_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   kind_type    req_kind = KIND_MOVE;
   logic [1:0]  req_move_direction = DIR_NONE;
   logic [31:0] req_pulse_count = 32'd0;
   logic        req_limit_is_max = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_accepted;
   status_type  rsp_axis_status;
   logic [31:0] rsp_position;
   logic        rsp_motor_running;
   logic        rsp_drive_backward;
   logic [31:0] rsp_max_position;

   axis_state_type  axis;
   axis_report_type pending_axis_reports[$];
   int              mismatches = 0;
   int              quiet_cycles = 0;
   bit              steady = 1'b0;   // suppress idling on both channels

   step_position_controller uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_kind           (req_kind),
      .req_move_direction (req_move_direction),
      .req_pulse_count    (req_pulse_count),
      .req_limit_is_max   (req_limit_is_max),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_accepted       (rsp_accepted),
      .rsp_axis_status    (rsp_axis_status),
      .rsp_position       (rsp_position),
      .rsp_motor_running  (rsp_motor_running),
      .rsp_drive_backward (rsp_drive_backward),
      .rsp_max_position   (rsp_max_position)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Axis predictor
   // ------------------------------------------------------------------------

   // Latch the emergency stop: motor off, only reset clears the status.
   function automatic void trip_estop();
      axis.running = 1'b0;
      axis.status  = ST_ESTOP;
   endfunction

   // Advance the predicted axis by one event and return the response it gives.
   function automatic axis_report_type axis_after_event(kind_type kind, dir_type dir,
                                                        logic [31:0] pulses, logic is_max);
      axis_report_type rep;
      longint unsigned len;
      len = 64'(pulses);
      rep = '0;
      case (kind)
         KIND_MOVE: begin
            // A zero-length move is taken in any status and does nothing
            if (pulses == 32'd0) begin
               rep.accepted = 1'b1;
            end else if (axis.status == ST_FREE && dir == DIR_FWD && len <= axis.top
                         && axis.pos <= axis.top - len) begin
               axis.target   = pos_type'(axis.pos + len);
               axis.pin_back = 1'b0;
               axis.status   = ST_FWD;
               axis.dir      = DIR_FWD;
               axis.running  = 1'b1;
               rep.accepted  = 1'b1;
            end else if (axis.status == ST_FREE && dir == DIR_BACK && len <= axis.pos) begin
               axis.target   = pos_type'(axis.pos - len);
               axis.pin_back = 1'b1;
               axis.status   = ST_BACK;
               axis.dir      = DIR_BACK;
               axis.running  = 1'b1;
               rep.accepted  = 1'b1;
            end
         end
         KIND_CAL: begin
            // Home downward from the far end; max is open until learned
            if (axis.status == ST_FREE) begin
               axis.pos      = POS_ONES;
               axis.target   = POS_ZERO;
               axis.top      = POS_ONES;
               axis.dir      = DIR_BACK;
               axis.pin_back = 1'b1;
               axis.status   = ST_CAL_MIN;
               axis.running  = 1'b1;
               rep.accepted  = 1'b1;
            end
         end
         KIND_STEP: begin
            // Ignore steps while the driver is off
            if (axis.running) begin
               if ((axis.dir == DIR_FWD && axis.pos >= axis.top)
                   || (axis.dir == DIR_BACK && axis.pos == POS_ZERO)
                   || (axis.dir != DIR_FWD && axis.dir != DIR_BACK)) begin
                  trip_estop();
               end else begin
                  axis.pos = (axis.dir == DIR_FWD) ? axis.pos + POS_ONE : axis.pos - POS_ONE;
                  if (axis.pos == axis.target) begin
                     axis.running = 1'b0;
                     axis.status  = ST_FREE;
                  end else if ((axis.dir == DIR_FWD) ? axis.pos > axis.target
                                                     : axis.pos < axis.target) begin
                     trip_estop();
                  end
               end
            end
         end
         KIND_LIMIT: begin
            axis.running = 1'b0;
            if (axis.status == ST_CAL_MIN && !is_max) begin
               // Home found: restart from zero toward the maximum switch
               axis.status   = ST_CAL_MAX;
               axis.pos      = POS_ZERO;
               axis.top      = POS_ONES;
               axis.dir      = DIR_FWD;
               axis.target   = POS_ONES;
               axis.pin_back = 1'b0;
               axis.running  = 1'b1;
            end else if (axis.status == ST_CAL_MAX) begin
               // Maximum switch learns the travel; minimum switch only stops
               if (is_max) begin
                  axis.target = POS_ZERO;
                  axis.dir    = DIR_NONE;
                  axis.top    = axis.pos;
                  axis.status = ST_FREE;
               end
            end else begin
               trip_estop();
            end
         end
         KIND_ESTOP: trip_estop();
         default: ;
      endcase
      rep.status   = axis.status;
      rep.position = axis.pos;
      rep.running  = axis.running;
      rep.backward = axis.pin_back;
      rep.max_pos  = axis.top;
      return rep;
   endfunction

   // ------------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------------

   // Send one transaction: idle a random while, hold the payload until the
   // block takes it, then queue the predicted response.
   task automatic send_event(kind_type kind, dir_type dir, logic [31:0] pulses,
                             logic is_max);
      while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_kind           <= kind;
      req_move_direction <= dir;
      req_pulse_count    <= pulses;
      req_limit_is_max   <= is_max;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      pending_axis_reports.push_back(axis_after_event(kind, dir, pulses, is_max));
   endtask

   // Drop valid and hold off until every queued response has come back.
   task automatic hold_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_axis_reports.size() != 0) @(posedge clock);
   endtask

   // One event that can never trip an emergency stop, whatever the status:
   // zero moves, moves too long for any learned travel, calibrate, step, or
   // a spare kind. All unused fields carry random values.
   task automatic send_noise();
      case ($urandom_range(4))
         0: send_event(KIND_MOVE, dir_type'($urandom), 32'd0, 1'($urandom));
         1: send_event(KIND_MOVE, dir_type'($urandom), $urandom | 32'h8000_0000,
                       1'($urandom));
         2: send_event(KIND_CAL, dir_type'($urandom), $urandom, 1'($urandom));
         3: send_event(KIND_STEP, dir_type'($urandom), $urandom, 1'($urandom));
         default: send_event(kind_type'($urandom_range(KIND_SPARE7, KIND_SPARE5)),
                             dir_type'($urandom), $urandom, 1'($urandom));
      endcase
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Commands on a fresh axis with no learned travel.
   task automatic test_commands_at_reset();
      send_event(KIND_MOVE, DIR_NONE, 32'd0, 1'b0);          // zero move, bad direction
      send_event(KIND_MOVE, DIR_FWD, 32'd1, 1'b0);           // beyond max of zero
      send_event(KIND_MOVE, DIR_BACK, 32'hFFFF_FFFF, 1'b1);  // below zero
      send_event(KIND_MOVE, DIR_BAD, 32'd5, 1'b0);
      send_event(KIND_MOVE, DIR_NONE, 32'd7, 1'b1);
      send_event(KIND_STEP, DIR_FWD, 32'hFFFF_FFFF, 1'b1);   // driver off
      send_event(KIND_SPARE5, DIR_BAD, 32'hFFFF_FFFF, 1'b1);
      send_event(KIND_SPARE7, DIR_BAD, 32'hFFFF_FFFF, 1'b1);
   endtask

   // Full homing run that learns a travel of three steps.
   task automatic test_calibration();
      send_event(KIND_CAL, DIR_NONE, 32'd0, 1'b0);
      send_event(KIND_CAL, DIR_FWD, 32'd1, 1'b1);            // busy
      send_event(KIND_STEP, DIR_NONE, 32'd0, 1'b0);
      send_event(KIND_LIMIT, DIR_NONE, 32'd0, 1'b0);         // minimum switch
      repeat (3) send_event(KIND_STEP, DIR_BAD, 32'd0, 1'b1);
      send_event(KIND_LIMIT, DIR_NONE, 32'd0, 1'b0);         // stray minimum switch
      send_event(KIND_STEP, DIR_NONE, 32'd0, 1'b0);          // motor already stopped
      send_event(KIND_LIMIT, DIR_NONE, 32'd0, 1'b1);         // learn max
   endtask

   // Moves at and just past both ends of the learned travel.
   task automatic test_travel_limits();
      send_event(KIND_MOVE, DIR_FWD, 32'd1, 1'b0);           // already at max
      send_event(KIND_MOVE, DIR_BACK, 32'd4, 1'b0);          // one past zero
      send_event(KIND_MOVE, DIR_BACK, 32'd3, 1'b1);          // exactly to zero
      send_event(KIND_CAL, DIR_NONE, 32'd0, 1'b0);           // busy
      repeat (3) send_event(KIND_STEP, DIR_FWD, 32'd0, 1'b0);
      send_event(KIND_MOVE, DIR_FWD, 32'd4, 1'b0);           // one past max
      send_event(KIND_MOVE, DIR_FWD, 32'd3, 1'b1);           // exactly to max
   endtask

   // Random but well-formed operation: pick each event from the predicted
   // status so that moves complete, calibrations run through and no
   // emergency stop is reached; mix in harmless noise.
   task automatic test_random_operation(int unsigned count);
      int unsigned pick;
      int unsigned room;
      int unsigned span;
      dir_type     dir;
      logic [31:0] len;
      for (int unsigned n = 0; n < count; n++) begin
         steady = (n >= count / 3 && n < count / 2);
         if (n == 2 * count / 3) hold_until_drained();
         pick = $urandom_range(99);
         case (axis.status)
            ST_FREE: begin
               room = axis.top - axis.pos;
               if (pick < 50 && (room != 0 || axis.pos != POS_ZERO)) begin
                  if (room != 0 && (axis.pos == POS_ZERO || $urandom_range(1) == 0)) begin
                     dir  = DIR_FWD;
                     span = room;
                  end else begin
                     dir  = DIR_BACK;
                     span = axis.pos;
                  end
                  // Mostly short moves, some to the end and some one past it
                  case ($urandom_range(9))
                     0: len = span + 1;
                     1: len = span;
                     default: len = $urandom_range(span < 40 ? span : 40, 1);
                  endcase
                  send_event(KIND_MOVE, dir, len, 1'($urandom));
               end else if (pick < 62) begin
                  send_event(KIND_CAL, dir_type'($urandom), $urandom, 1'($urandom));
               end else if (pick < 80) begin
                  send_event(KIND_MOVE, dir_type'($urandom), $urandom, 1'($urandom));
               end else if (pick < 88) begin
                  send_event(KIND_MOVE, dir_type'($urandom), 32'd0, 1'($urandom));
               end else begin
                  send_noise();
               end
            end
            ST_FWD, ST_BACK: begin
               if (pick < 80)
                  send_event(KIND_STEP, dir_type'($urandom), $urandom, 1'($urandom));
               else send_noise();
            end
            ST_CAL_MIN: begin
               if (pick < 60)
                  send_event(KIND_STEP, dir_type'($urandom), $urandom, 1'($urandom));
               else if (pick < 80)
                  send_event(KIND_LIMIT, dir_type'($urandom), $urandom, 1'b0);
               else send_noise();
            end
            ST_CAL_MAX: begin
               if (axis.running) begin
                  if (axis.pos >= CAL_SPAN_CAP || pick < 4)
                     send_event(KIND_LIMIT, dir_type'($urandom), $urandom, 1'b1);
                  else if (pick < 7)
                     send_event(KIND_LIMIT, dir_type'($urandom), $urandom, 1'b0);
                  else if (pick < 92)
                     send_event(KIND_STEP, dir_type'($urandom), $urandom, 1'($urandom));
                  else
                     send_noise();
               end else begin
                  if (pick < 50)
                     send_event(KIND_LIMIT, dir_type'($urandom), $urandom, 1'b1);
                  else if (pick < 75)
                     send_event(KIND_LIMIT, dir_type'($urandom), $urandom, 1'b0);
                  else send_noise();
               end
            end
            default: send_noise();
         endcase
      end
      steady = 1'b0;
   endtask

   // Trip the emergency stop, by command or by a limit switch out of
   // sequence, then show that the random events after it leave it latched.
   task automatic test_emergency_stop();
      if (axis.status == ST_CAL_MAX || $urandom_range(1) == 0)
         send_event(KIND_ESTOP, dir_type'($urandom), $urandom, 1'($urandom));
      else
         send_event(KIND_LIMIT, dir_type'($urandom), $urandom,
                    (axis.status == ST_CAL_MIN) ? 1'b1 : 1'($urandom));
      repeat (12) begin
         send_event(kind_type'($urandom_range(KIND_SPARE7)), dir_type'($urandom),
                    ($urandom_range(3) == 0) ? 32'd0 : $urandom, 1'($urandom));
      end
   endtask

   // ------------------------------------------------------------------------
   // Response side
   // ------------------------------------------------------------------------

   // Stall the response channel at random, except in the steady stretch.
   always @(posedge clock) begin
      rsp_stall <= !steady && ($urandom_range(99) < IDLE_PERCENT);
   end

   task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("mismatch on %s at %0t: expected %0h, got %0h", name, $time, want, got);
      end
   endtask

   // Compare every accepted response with the oldest prediction.
   always @(posedge clock) begin : check_responses
      axis_report_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_axis_reports.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("mismatch at %0t: response with nothing expected", $time);
         end else begin
            want = pending_axis_reports.pop_front();
            check_field("accepted", 32'(rsp_accepted), 32'(want.accepted));
            check_field("axis_status", 32'(rsp_axis_status), 32'(want.status));
            check_field("position", rsp_position, 32'(want.position));
            check_field("motor_running", 32'(rsp_motor_running), 32'(want.running));
            check_field("drive_backward", 32'(rsp_drive_backward), 32'(want.backward));
            check_field("max_position", rsp_max_position, 32'(want.max_pos));
         end
      end
   end

   // Watchdog: end the run when no transaction moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_step_position_controller NOT OK");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      axis = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_commands_at_reset();
      test_calibration();
      test_travel_limits();
      test_random_operation(RANDOM_EVENTS);
      test_emergency_stop();

      // Drain the response queue, then watch for stray responses
      req_valid <= 1'b0;
      while (pending_axis_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatches == 0 && pending_axis_reports.size() == 0)
         $display("tb_step_position_controller OK");
      else
         $display("tb_step_position_controller NOT OK");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/spc_pkg.sv
rtl/core/step_position_controller.sv
test/tb_step_position_controller.sv
